// ----- design/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned STEP_W        = 10;
    localparam int unsigned PHASE_W       = 5;
    localparam int unsigned BCNT_W        = 4;

    localparam logic [STEP_W-1:0]  STEP_TICKS_RESET = 10'd80;

    // phase boundaries of the byte sequences
    localparam logic [PHASE_W-1:0] WR_ACK_PHASE  = 5'(3 * BITS_PER_BYTE);
    localparam logic [PHASE_W-1:0] RD_ACK_PHASE  = 5'(2 * BITS_PER_BYTE);
    localparam logic [PHASE_W-1:0] START_LAST    = 5'd3;
    localparam logic [PHASE_W-1:0] STOP_LAST     = 5'd2;
    localparam logic [PHASE_W-1:0] WRITE_LAST    = 5'(3 * BITS_PER_BYTE + 1);
    localparam logic [PHASE_W-1:0] READ_LAST     = 5'(2 * BITS_PER_BYTE + 3);

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       rd_ack;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } t_result;

    function automatic logic [PHASE_W-1:0] last_step(input t_cmd cmd);
        logic [PHASE_W-1:0] v;
        unique case (cmd)
            CMD_START: v = START_LAST;
            CMD_STOP:  v = STOP_LAST;
            CMD_WRITE: v = WRITE_LAST;
            default:   v = READ_LAST;
        endcase
        return v;
    endfunction

endpackage

// ----- design/i2cm_engine.sv -----
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_item             i_item,
    input  logic [STEP_W-1:0] i_step_ticks,
    output t_result           o_res
);

    t_cmd               r_cmd, n_cmd;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_shift, n_shift;
    logic [BCNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [STEP_W-1:0]  r_hold, n_hold;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_sda_in, n_sda_in;
    logic               r_ack, n_ack;
    logic               r_ack_choice, n_ack_choice;
    logic [7:0]         r_read, n_read;
    logic               done;

    // next state
    always_comb begin
        logic               apply;
        logic [PHASE_W-1:0] rem_cur;
        logic [PHASE_W-1:0] rem_nxt;

        n_cmd        = r_cmd;
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_hold       = r_hold;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_in     = r_sda_in;
        n_ack        = r_ack;
        n_ack_choice = r_ack_choice;
        n_read       = r_read;
        done         = 1'b0;
        apply        = 1'b0;
        // write phase within its bit: phase - 3 * bits done
        rem_cur = r_phase - {r_bit_cnt, 1'b0} - PHASE_W'(r_bit_cnt);

        if (i_en) begin
            if (r_cmd == CMD_NONE) begin
                case (i_item.operation)
                    CMD_START, CMD_WRITE, CMD_READ, CMD_STOP: begin
                        n_cmd        = t_cmd'(i_item.operation);
                        n_phase      = '0;
                        n_bit_cnt    = '0;
                        n_ack_choice = i_item.rd_ack;
                        if (i_item.operation == CMD_WRITE) begin
                            n_shift = i_item.write_data;
                        end else if (i_item.operation == CMD_READ) begin
                            n_shift = '0;
                        end
                        apply = 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_hold != '0) begin
                n_hold = r_hold - 1'b1;
            end else begin
                // hold over: take samples belonging to this step
                if (r_cmd == CMD_WRITE) begin
                    if (r_phase < WR_ACK_PHASE && rem_cur == 5'd2) begin
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                    end else if (r_phase == WR_ACK_PHASE) begin
                        n_ack = ~i_item.sda_sample;
                    end
                end else if (r_cmd == CMD_READ) begin
                    if (r_phase < RD_ACK_PHASE && !r_phase[0]) begin
                        n_shift   = {r_shift[6:0], i_item.sda_sample};
                        n_bit_cnt = r_bit_cnt + 1'b1;
                    end
                end

                if (r_phase >= last_step(r_cmd)) begin
                    if (r_cmd == CMD_WRITE) begin
                        n_sda_in = 1'b0;
                    end
                    if (r_cmd == CMD_READ) begin
                        n_read = n_shift;
                    end
                    n_cmd   = CMD_NONE;
                    n_phase = '0;
                    done    = 1'b1;
                end else begin
                    n_phase = r_phase + 1'b1;
                    apply   = 1'b1;
                end
            end
        end

        rem_nxt = n_phase - {n_bit_cnt, 1'b0} - PHASE_W'(n_bit_cnt);

        if (apply) begin
            unique case (n_cmd)
                CMD_START: begin
                    unique case (n_phase)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    unique case (n_phase)
                        5'd0:    n_sda = 1'b0;
                        5'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    if (n_phase < WR_ACK_PHASE) begin
                        case (rem_nxt)
                            5'd0:    n_sda = n_shift[7];
                            5'd1:    n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end else if (n_phase == WR_ACK_PHASE) begin
                        n_sda_in = 1'b1;
                        n_scl    = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: begin
                    if (n_phase < RD_ACK_PHASE) begin
                        if (!n_phase[0]) begin
                            n_sda_in = 1'b1;
                            n_scl    = 1'b1;
                        end else begin
                            n_scl = 1'b0;
                        end
                    end else if (n_phase == RD_ACK_PHASE) begin
                        n_sda_in = 1'b0;
                        n_sda    = ~n_ack_choice;
                    end else if (n_phase == RD_ACK_PHASE + 5'd1) begin
                        n_scl = 1'b1;
                    end else if (n_phase == RD_ACK_PHASE + 5'd2) begin
                        n_scl = 1'b0;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
            endcase
            // zero hold setting acts as one
            n_hold = (i_step_ticks == '0) ? '0 : i_step_ticks - 1'b1;
        end
    end

    // result of this item
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda_in | n_sda;
        o_res.busy_res  = (n_cmd != CMD_NONE);
        o_res.done_res  = done;
        o_res.read_data = n_read;
        o_res.ack_seen  = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_NONE;
            r_phase      <= '0;
            r_shift      <= '0;
            r_bit_cnt    <= '0;
            r_hold       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_in     <= 1'b0;
            r_ack        <= 1'b0;
            r_ack_choice <= 1'b0;
            r_read       <= '0;
        end else begin
            r_cmd        <= n_cmd;
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_bit_cnt    <= n_bit_cnt;
            r_hold       <= n_hold;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_in     <= n_sda_in;
            r_ack        <= n_ack;
            r_ack_choice <= n_ack_choice;
            r_read       <= n_read;
        end
    end

    a_idle_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd == CMD_NONE |-> r_phase == '0)
        else $error("phase not zero while idle");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'(BITS_PER_BYTE))
        else $error("bit count beyond one byte");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && done |=> r_cmd == CMD_NONE && !r_sda_in)
        else $error("engine not idle after done");

    a_no_step_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_cmd != CMD_NONE && r_hold != '0 |=> $stable(r_phase))
        else $error("phase moved during hold");

endmodule

// ----- design/i2c_master_byte_sequencer.sv -----
`timescale 1ns / 1ps

// I2C master byte engine, one item per timing tick.
// Input channel (i_in_valid / o_in_ready): each item is one tick carrying the
// sampled SDA level and, while idle, an optional command (start, write byte,
// read byte, stop). Commands given while busy are ignored.
// Output channel (o_out_valid / i_out_ready): exactly one result per item with
// the SCL and SDA drive levels, busy, done, last read byte and write ack seen.
// Every pin level is held for step_ticks ticks, set by i_cfg_wr_en and
// i_cfg_wr_data (reset value 80); the user must write it only while the engine
// is idle, the block itself does not enforce this. An accepted item passes
// through the input register, the engine step and the result register.
// Throughput: one item per cycle while results leave; state updates in one pass.
// A stalled receiver stops the engine and holds the result register; the input
// register then takes one more item and ready drops until the result leaves.
// Synchronous reset: both registers empty, bus released (SCL and SDA high),
// engine idle, step_ticks back to 80.

module i2c_master_byte_sequencer
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [STEP_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_write_data,
    input  logic              i_rd_ack,
    input  logic              i_sda_sample,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_scl_level,
    output logic              o_sda_level,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [7:0]        o_read_data,
    output logic              o_ack_seen
);

    logic [STEP_W-1:0] r_step_ticks;
    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_res;
    t_result           eng_res;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks <= STEP_TICKS_RESET;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step_ticks <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.operation  <= i_operation;
            r_item.write_data <= i_write_data;
            r_item.rd_ack     <= i_rd_ack;
            r_item.sda_sample <= i_sda_sample;
        end
        if (advance) begin
            r_res <= eng_res;
        end
    end

    i2cm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_item),
        .i_step_ticks (r_step_ticks),
        .o_res        (eng_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_res.scl_level;
    assign o_sda_level = r_res.sda_level;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_read_data = r_res.read_data;
    assign o_ack_seen  = r_res.ack_seen;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not filled after engine step");

    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_item))
        else $error("pending item lost during stall");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_res))
        else $error("result changed while receiver stalled");

endmodule
